@@ sv/tsrw_pkg.sv @@
package tsrw_pkg;

    localparam int KIND_W          = 2;
    localparam int IDX_W           = 10;
    localparam int LIT_W           = 12;
    localparam int PICK_W          = 31;
    localparam int CFG_W           = 11;
    localparam int VAR_W           = 10;
    localparam int VAR_COUNT       = 1024;
    localparam int CLAUSE_W        = 2 * (VAR_W + 1);
    localparam int MAX_CLAUSES_DEF = 1024;
    localparam int CFG_RESET       = 1;
    localparam int BIT_W           = $clog2(PICK_W);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 2'd0,
        KIND_SET  = 2'd1,
        KIND_STEP = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_MOD,
        ST_FIND,
        ST_FLIP,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic clear_we;
        logic clause_we;
        logic var_we;
        logic scan_init;
        logic scan_en;
        logic count_en;
        logic mod_init;
        logic mod_en;
        logic find_en;
        logic flip_we;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_done;
        logic count_zero;
        logic mod_last;
    } status_t;

endpackage

@@ sv/tsrw_ram.sv @@
module tsrw_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/tsrw_ctrl.sv @@
module tsrw_ctrl
    import tsrw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KIND_W-1:0] kind,
    input  status_t           status,
    output cmd_t              cmd,
    output logic              busy,
    output logic              done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start && kind == KIND_STEP)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (status.scan_done)
                begin
                    state_next = status.count_zero ? ST_REPORT : ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (status.mod_last)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_FLIP;
                end
            end
            ST_FLIP:   state_next = ST_REPORT;
            ST_REPORT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    case (kind)
                        KIND_LOAD: cmd.clause_we = 1'b1;
                        KIND_SET:  cmd.var_we    = 1'b1;
                        KIND_STEP: cmd.scan_init = 1'b1;
                        default:   cmd           = '0;
                    endcase
                end
            end
            ST_COUNT:
            begin
                cmd.scan_en  = 1'b1;
                cmd.count_en = 1'b1;
                cmd.mod_init = status.scan_done && !status.count_zero;
            end
            ST_MOD:
            begin
                cmd.mod_en = 1'b1;
            end
            ST_FIND:
            begin
                cmd.scan_en = 1'b1;
                cmd.find_en = 1'b1;
            end
            ST_FLIP:
            begin
                cmd.flip_we = 1'b1;
            end
            ST_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ sv/tsrw_datapath.sv @@
module tsrw_datapath
    import tsrw_pkg::*;
#(
    parameter int MAX_CLAUSES = MAX_CLAUSES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic                    cfg_valid,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic [IDX_W-1:0]        index,
    input  logic signed [LIT_W-1:0] first_literal,
    input  logic signed [LIT_W-1:0] second_literal,
    input  logic                    truth_value,
    input  logic [PICK_W-1:0]       pick,
    input  logic                    side,
    output logic [CFG_W-1:0]        violation_count,
    output logic                    satisfied,
    output logic [VAR_W-1:0]        flipped_variable
);

    localparam int AW = $clog2(MAX_CLAUSES);

    typedef struct packed {
        logic             neg2;
        logic [VAR_W-1:0] var2;
        logic             neg1;
        logic [VAR_W-1:0] var1;
    } clause_t;

    // sign bit plus 0-based variable, magnitude minus one wraps
    function automatic logic [VAR_W:0] encode_lit(input logic [LIT_W-1:0] raw);
        logic [LIT_W-1:0] mag;
        logic [LIT_W-1:0] dec;
        begin
            mag = raw[LIT_W-1] ? (LIT_W'(0) - raw) : raw;
            dec = mag - LIT_W'(1);
            return {raw[LIT_W-1], dec[VAR_W-1:0]};
        end
    endfunction

    logic [CFG_W-1:0]  cfg_reg;
    logic [CFG_W-1:0]  scan_len;
    logic [CFG_W-1:0]  scan_idx_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              issue;
    clause_t           clause_wdata;
    clause_t           clause_rdata;
    clause_t           c2_reg;
    logic              a_rdata;
    logic              b_rdata;
    logic              violated;
    logic [CFG_W-1:0]  count_reg;
    logic [PICK_W-1:0] pick_reg;
    logic              side_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [CFG_W-1:0]  rem_next;
    logic [CFG_W:0]    shifted;
    logic [BIT_W-1:0]  bit_reg;
    logic [CFG_W-1:0]  seen_reg;
    logic              found_reg;
    logic [VAR_W-1:0]  flip_var_reg;
    logic              flip_bit_reg;
    logic [VAR_W-1:0]  clr_reg;
    logic              var_we;
    logic [VAR_W-1:0]  var_waddr;
    logic              var_wdata;
    logic              clause_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_W'(CFG_RESET);
        end
        else if (cfg_valid)
        begin
            cfg_reg <= cfg_data;
        end
    end

    assign scan_len = (32'(cfg_reg) > MAX_CLAUSES) ? CFG_W'(MAX_CLAUSES) : cfg_reg;

    // clause table
    assign clause_wdata = {encode_lit(second_literal), encode_lit(first_literal)};
    assign clause_we    = cmd.clause_we && (32'(index) < MAX_CLAUSES);

    tsrw_ram #(
        .WIDTH (CLAUSE_W),
        .DEPTH (MAX_CLAUSES)
    ) u_clause_ram (
        .clk   (clk),
        .we    (clause_we),
        .waddr (AW'(index)),
        .wdata (clause_wdata),
        .raddr (AW'(scan_idx_reg)),
        .rdata (clause_rdata)
    );

    // assignment kept in two copies, one read port per literal
    always_comb
    begin
        var_we    = cmd.clear_we || cmd.var_we || cmd.flip_we;
        var_waddr = flip_var_reg;
        var_wdata = ~flip_bit_reg;
        if (cmd.clear_we)
        begin
            var_waddr = clr_reg;
            var_wdata = 1'b0;
        end
        else if (cmd.var_we)
        begin
            var_waddr = index;
            var_wdata = truth_value;
        end
    end

    tsrw_ram #(
        .WIDTH (1),
        .DEPTH (VAR_COUNT)
    ) u_var_ram_a (
        .clk   (clk),
        .we    (var_we),
        .waddr (var_waddr),
        .wdata (var_wdata),
        .raddr (clause_rdata.var1),
        .rdata (a_rdata)
    );

    tsrw_ram #(
        .WIDTH (1),
        .DEPTH (VAR_COUNT)
    ) u_var_ram_b (
        .clk   (clk),
        .we    (var_we),
        .waddr (var_waddr),
        .wdata (var_wdata),
        .raddr (clause_rdata.var2),
        .rdata (b_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_we)
        begin
            clr_reg <= clr_reg + VAR_W'(1);
        end
    end

    // scan pipeline: clause read, then variable read, then evaluate
    assign issue = cmd.scan_en && (scan_idx_reg < scan_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
        end
        else if (cmd.scan_init || cmd.mod_init)
        begin
            scan_idx_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
        end
        else if (cmd.scan_en)
        begin
            scan_idx_reg <= scan_idx_reg + CFG_W'(issue);
            v1_reg       <= issue;
            v2_reg       <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c2_reg <= clause_rdata;
    end

    assign violated = v2_reg && !(a_rdata ^ c2_reg.neg1) && !(b_rdata ^ c2_reg.neg2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.scan_init)
        begin
            count_reg <= '0;
        end
        else if (cmd.count_en && violated)
        begin
            count_reg <= count_reg + CFG_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            pick_reg <= pick;
            side_reg <= side;
        end
    end

    // pick mod count, one bit per cycle, msb first
    assign shifted  = {rem_reg, pick_reg[bit_reg]};
    assign rem_next = (shifted >= {1'b0, count_reg}) ? CFG_W'(shifted - {1'b0, count_reg})
                                                     : CFG_W'(shifted);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            bit_reg <= '0;
        end
        else if (cmd.mod_init)
        begin
            rem_reg <= '0;
            bit_reg <= BIT_W'(PICK_W - 1);
        end
        else if (cmd.mod_en)
        begin
            rem_reg <= rem_next;
            bit_reg <= bit_reg - BIT_W'(1);
        end
    end

    // second pass records the chosen violated clause and ignores later ones
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            found_reg    <= 1'b0;
            flip_var_reg <= '0;
            flip_bit_reg <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            flip_var_reg <= '0;
        end
        else if (cmd.mod_init)
        begin
            seen_reg  <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.find_en && violated && !found_reg)
        begin
            if (seen_reg == rem_reg)
            begin
                found_reg    <= 1'b1;
                flip_var_reg <= side_reg ? c2_reg.var2 : c2_reg.var1;
                flip_bit_reg <= side_reg ? b_rdata : a_rdata;
            end
            else
            begin
                seen_reg <= seen_reg + CFG_W'(1);
            end
        end
    end

    assign status.clear_last = (clr_reg == VAR_W'(VAR_COUNT - 1));
    assign status.scan_done  = !(scan_idx_reg < scan_len) && !v1_reg && !v2_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.mod_last   = (bit_reg == '0);

    assign violation_count  = count_reg;
    assign satisfied        = (count_reg == '0);
    assign flipped_variable = flip_var_reg;

endmodule

@@ sv/two_sat_random_walk_step.sv @@
// random-walk 2-sat search step
// input: an item is taken at a clock edge with start high and busy low.
//   kind selects load clause (index, first_literal, second_literal),
//   set variable (index, truth_value) or search step (pick, side).
//   load and set finish in the accept cycle and give no result; busy stays low.
// output: a step gives one result word (violation_count, satisfied,
//   flipped_variable) shown for exactly one cycle while done is high.
//   the receiver cannot stall; the result must be taken in that cycle.
// config: clauses_in_use is written through cfg_valid/cfg_ready/cfg_data,
//   cfg_ready is always high; write only while busy is low.
// search: a step reads the clause table once a cycle in two full passes
//   (count, then find) with a bit-serial remainder unit between them;
//   a satisfied step runs only the count pass.
// reset: rst_n is asynchronous, active low. after reset the block runs a
//   pass clearing all 1024 truth bits with busy high.
//   clauses_in_use resets to 1; clause slots read unwritten are undefined.
module two_sat_random_walk_step
    import tsrw_pkg::*;
#(
    parameter int MAX_CLAUSES = MAX_CLAUSES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [KIND_W-1:0]       kind,
    input  logic [IDX_W-1:0]        index,
    input  logic signed [LIT_W-1:0] first_literal,
    input  logic signed [LIT_W-1:0] second_literal,
    input  logic                    truth_value,
    input  logic [PICK_W-1:0]       pick,
    input  logic                    side,
    output logic                    done,
    output logic [CFG_W-1:0]        violation_count,
    output logic                    satisfied,
    output logic [VAR_W-1:0]        flipped_variable,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_W-1:0]        cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    tsrw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tsrw_datapath #(
        .MAX_CLAUSES (MAX_CLAUSES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .index            (index),
        .first_literal    (first_literal),
        .second_literal   (second_literal),
        .truth_value      (truth_value),
        .pick             (pick),
        .side             (side),
        .violation_count  (violation_count),
        .satisfied        (satisfied),
        .flipped_variable (flipped_variable)
    );

endmodule
